// ----- design/rbs_pkg.sv -----
// Package for the record bubble sorter: transaction payload structs, command codes,
// controller state type and the controller-to-datapath command and status structs.
// Depends on nothing; every other design file imports it.
`default_nettype none

package rbs_pkg;

	// Width of the record length configuration register and its value after reset.
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] RECORD_LEN_RESET = 5'd4;

	// Item command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// One input transaction.
	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       out_error;
	} out_item_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAIR,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_SWP_RD,
		ST_SWP_WA,
		ST_SWP_WB
	} rbs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_wr;      // store the item byte at the fill position
		logic rd_item;      // return the byte at the read position
		logic sort_init;    // first pass starts at record zero
		logic pass_restart; // another pass starts at record zero
		logic cmp_rd;       // read byte k of both records of the pair
		logic k_inc;        // next byte of the pair
		logic k_clr;        // back to byte zero of the pair
		logic pair_next;    // move to the next adjacent pair
		logic swap_wa;      // write the second record's byte into the first
		logic swap_wb;      // write the first record's byte into the second
		logic mark_swap;    // note that this pass swapped a pair
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pair_ok;  // a whole second record follows the current one
		logic k_last;   // byte index is the last one of a record
		logic rec_gt;   // first byte read is greater, signed
		logic rec_lt;   // first byte read is smaller, signed
		logic swapped;  // the current pass has swapped at least once
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- design/record_bubble_sorter_top.sv -----
// Top level of the record bubble sorter: joins the controller and the datapath.
// Depends on rbs_pkg, rbs_ctrl and rbs_datapath.
`default_nettype none

// Load and read transactions are taken one per cycle while busy is low. A read gives
// its result in the cycle after acceptance, shown on result for that single cycle with
// result_valid high; the receiver cannot stall, so it must take it then. A load marked
// last_byte raises busy for the sort. The sort is limited by the one write port of the
// byte store: for N whole records of L bytes each pass visits N-1 adjacent pairs, a pair
// takes a check step plus a read and an evaluate step per compared byte, a swap adds a
// read and two writes per byte, and the sort ends after the first pass without a swap,
// so at most N passes, each closed by a final pair check. The store needs no clearing
// after reset. The record length register is written only while busy is low.
module record_bubble_sorter_top #(
	parameter int MAX_RECORDS    = 256,
	parameter int MAX_RECORD_LEN = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  rbs_pkg::in_item_t           item,
	output logic                       result_valid,
	output rbs_pkg::out_item_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rbs_pkg::CFG_W-1:0]  cfg_data
);
	import rbs_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	// Configuration is taken whenever no sort runs.
	assign cfg_ready = !busy;

	// Controller.
	rbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Datapath.
	rbs_datapath #(
		.MAX_RECORDS    (MAX_RECORDS),
		.MAX_RECORD_LEN (MAX_RECORD_LEN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- design/rbs_ctrl.sv -----
// Controller of the record bubble sorter: accepts transactions and steps the sort
// through pair compare and byte swap sequences. Depends on rbs_pkg.
`default_nettype none

module rbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rbs_pkg::in_item_t item,
	input  rbs_pkg::dp_stat_t stat,
	output logic             busy,
	output rbs_pkg::dp_cmd_t  ctl
);
	import rbs_pkg::*;

	rbs_state_t state_q;
	rbs_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && item.cmd == CMD_LOAD && item.last_byte) begin
					state_d = ST_PAIR;
				end
			end
			ST_PAIR: begin
				if (stat.pair_ok) begin
					state_d = ST_CMP_RD;
				end else if (!stat.swapped) begin
					state_d = ST_IDLE;
				end
			end
			ST_CMP_RD: begin
				state_d = ST_CMP_EV;
			end
			ST_CMP_EV: begin
				if (stat.rec_gt) begin
					state_d = ST_SWP_RD;
				end else if (stat.rec_lt || stat.k_last) begin
					state_d = ST_PAIR;
				end else begin
					state_d = ST_CMP_RD;
				end
			end
			ST_SWP_RD: begin
				state_d = ST_SWP_WA;
			end
			ST_SWP_WA: begin
				state_d = ST_SWP_WB;
			end
			ST_SWP_WB: begin
				if (stat.k_last) begin
					state_d = ST_PAIR;
				end else begin
					state_d = ST_SWP_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath commands.
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.cmd == CMD_LOAD) begin
						ctl.load_wr   = 1'b1;
						ctl.sort_init = item.last_byte;
					end else begin
						ctl.rd_item = 1'b1;
					end
				end
			end
			ST_PAIR: begin
				ctl.pass_restart = !stat.pair_ok && stat.swapped;
			end
			ST_CMP_RD: begin
				ctl.cmp_rd = 1'b1;
			end
			ST_CMP_EV: begin
				if (stat.rec_gt) begin
					ctl.k_clr = 1'b1;
				end else if (stat.rec_lt || stat.k_last) begin
					ctl.pair_next = 1'b1;
				end else begin
					ctl.k_inc = 1'b1;
				end
			end
			ST_SWP_RD: begin
				ctl.cmp_rd = 1'b1;
			end
			ST_SWP_WA: begin
				ctl.swap_wa = 1'b1;
			end
			ST_SWP_WB: begin
				ctl.swap_wb = 1'b1;
				if (stat.k_last) begin
					ctl.pair_next = 1'b1;
					ctl.mark_swap = 1'b1;
				end else begin
					ctl.k_inc = 1'b1;
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// The first swap write always follows the read of both bytes.
	a_swap_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWP_WA |-> $past(state_q) == ST_SWP_RD)
		else $error("swap write without preceding byte read");

	// A sort never ends in the middle of a pass that swapped.
	a_done_clean_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAIR && state_d == ST_IDLE |-> !stat.swapped && !stat.pair_ok)
		else $error("sort finished while a pass still swapped");

endmodule

`default_nettype wire

// ----- design/rbs_datapath.sv -----
// Datapath of the record bubble sorter: byte store memory, fill and read counters,
// record length register, pair pointers, signed byte compare and result registers.
// Depends on rbs_pkg.
`default_nettype none

module rbs_datapath #(
	parameter int MAX_RECORDS    = 256,
	parameter int MAX_RECORD_LEN = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbs_pkg::dp_cmd_t             ctl,
	input  rbs_pkg::in_item_t            item,
	input  logic                        cfg_we,
	input  logic [rbs_pkg::CFG_W-1:0]   cfg_data,
	output rbs_pkg::dp_stat_t            stat,
	output logic                        result_valid,
	output rbs_pkg::out_item_t           result
);
	import rbs_pkg::*;

	localparam int DEPTH = MAX_RECORDS * MAX_RECORD_LEN;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int LW    = $clog2(MAX_RECORD_LEN + 1);

	logic [CFG_W-1:0] record_length_q;
	logic [LW-1:0]    len_eff;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    read_pos_q;
	logic             overflow_q;
	logic [CW-1:0]    base_q;
	logic [LW-1:0]    k_q;
	logic             swapped_q;
	logic [7:0]       ra_q;
	logic [7:0]       rb_q;
	logic             res_valid_q;
	logic             past_end_q;
	logic             last_q;
	logic             err_q;

	logic [7:0]       mem [DEPTH];
	logic [AW-1:0]    addr_a;
	logic [AW-1:0]    addr_b;
	logic [AW-1:0]    raddr_a;
	logic             re_a;
	logic             re_b;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;
	logic             has_room;
	logic             item_avail;
	logic [CW:0]      pair_end;

	// Record length as used: zero acts as one, oversize values saturate.
	always_comb begin
		if (record_length_q == '0) begin
			len_eff = LW'(1);
		end else if (int'(record_length_q) > MAX_RECORD_LEN) begin
			len_eff = LW'(MAX_RECORD_LEN);
		end else begin
			len_eff = LW'(record_length_q);
		end
	end

	// Byte addresses within the current pair and the end of the second record.
	assign addr_a   = AW'((CW+1)'(base_q) + (CW+1)'(k_q));
	assign addr_b   = AW'((CW+1)'(base_q) + (CW+1)'(len_eff) + (CW+1)'(k_q));
	assign pair_end = (CW+1)'(base_q) + (CW+1)'(len_eff) + (CW+1)'(len_eff);

	assign has_room   = (count_q < CW'(DEPTH));
	assign item_avail = (read_pos_q < count_q);

	// Memory port selection.
	always_comb begin
		raddr_a = ctl.rd_item ? read_pos_q[AW-1:0] : addr_a;
		re_a    = (ctl.rd_item && item_avail) || ctl.cmp_rd;
		re_b    = ctl.cmp_rd;
		we      = (ctl.load_wr && has_room) || ctl.swap_wa || ctl.swap_wb;
		if (ctl.swap_wa) begin
			waddr = addr_a;
			wdata = rb_q;
		end else if (ctl.swap_wb) begin
			waddr = addr_b;
			wdata = ra_q;
		end else begin
			waddr = count_q[AW-1:0];
			wdata = item.data_byte;
		end
	end

	// Byte store: one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			ra_q <= mem[raddr_a];
		end
		if (re_b) begin
			rb_q <= mem[addr_b];
		end
	end

	// Configuration, fill and read counters, pair pointers and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_length_q <= RECORD_LEN_RESET;
			count_q         <= '0;
			read_pos_q      <= '0;
			overflow_q      <= 1'b0;
			base_q          <= '0;
			k_q             <= '0;
			swapped_q       <= 1'b0;
			res_valid_q     <= 1'b0;
			past_end_q      <= 1'b0;
			last_q          <= 1'b0;
			err_q           <= 1'b0;
		end else begin
			if (cfg_we) begin
				record_length_q <= cfg_data;
			end
			if (ctl.load_wr) begin
				if (has_room) begin
					count_q <= count_q + CW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			res_valid_q <= ctl.rd_item;
			if (ctl.rd_item) begin
				if (item_avail) begin
					read_pos_q <= read_pos_q + CW'(1);
					past_end_q <= 1'b0;
					last_q     <= (read_pos_q + CW'(1) == count_q);
					err_q      <= overflow_q;
				end else begin
					past_end_q <= 1'b1;
					last_q     <= 1'b0;
					err_q      <= 1'b1;
				end
			end
			if (ctl.sort_init) begin
				read_pos_q <= '0;
				base_q     <= '0;
				k_q        <= '0;
				swapped_q  <= 1'b0;
			end
			if (ctl.pass_restart) begin
				base_q    <= '0;
				k_q       <= '0;
				swapped_q <= 1'b0;
			end
			if (ctl.pair_next) begin
				base_q <= base_q + CW'(len_eff);
				k_q    <= '0;
			end else if (ctl.k_clr) begin
				k_q <= '0;
			end else if (ctl.k_inc) begin
				k_q <= k_q + LW'(1);
			end
			if (ctl.mark_swap) begin
				swapped_q <= 1'b1;
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.pair_ok = (pair_end <= (CW+1)'(count_q));
		stat.k_last  = (k_q == len_eff - LW'(1));
		stat.rec_gt  = ($signed(ra_q) > $signed(rb_q));
		stat.rec_lt  = ($signed(ra_q) < $signed(rb_q));
		stat.swapped = swapped_q;
	end

	// Result transaction.
	assign result_valid     = res_valid_q;
	assign result.out_byte  = past_end_q ? 8'h00 : ra_q;
	assign result.out_last  = last_q;
	assign result.out_error = err_q;

	// The fill count never passes the store size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("byte count beyond store size");

	// The read position never passes the fill count.
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		read_pos_q <= count_q)
		else $error("read position beyond byte count");

	// Every read command gives exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid == $past(ctl.rd_item))
		else $error("result strobe not tied to a read command");

endmodule

`default_nettype wire
